@@ hw/rtl/sequential_list_engine_macros.svh @@
// assertion helpers for the list engine, clocked on i_clk, off during reset
`ifndef SEQUENTIAL_LIST_ENGINE_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_MACROS_SVH

// expression must hold at every edge out of reset
`define SLE_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sle_pkg.sv @@
package sle_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int FUNC_W  = 3;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MODIFY = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic [POS_W-1:0]          found_position;
        logic signed [VALUE_W-1:0] data;
        logic [POS_W-1:0]          count;
    } t_out_item;

endpackage

@@ hw/rtl/sle_mem.sv @@
module sle_mem
    import sle_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [VALUE_W-1:0] i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output logic [VALUE_W-1:0] o_rdata
);

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/sequential_list_engine.sv @@
// Ordered list of up to CAPACITY signed 32-bit entries kept in an entry RAM
// with one write port and one registered read port, and run by a small
// sequencer around one equality comparator and a shared pointer incrementer and decrementer.
// Each accepted transfer carries func, a 1-based position and a value, and
// gives exactly one result transfer with status, found position, data and
// the entry count after the operation. The input is taken only while the
// sequencer is idle; a finished result waits in an output register.
// With n entries and position p: errors and unused func codes go straight
// to the result; read and modify fetch one entry; delete moves entries
// p+1..n down one place; insert moves entries p..n up one place from the
// tail; search checks entries from 1 until the first match or the end.
// Every shifted or compared entry is read from the registered RAM port
// and written or checked in the cycle after. The block takes the next item
// in the cycle after the result is loaded. The list starts empty after
// reset; RAM contents are never cleared and only entries 1..count are
// ever read.
module sequential_list_engine
    import sle_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

`include "sequential_list_engine_macros.svh"

    // index into the RAM, and count wide enough to hold CAPACITY itself
    localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    // compare width for position against count
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEL,
        S_DELW,
        S_INS,
        S_INSW,
        S_SRCH,
        S_SRCHW,
        S_RD,
        S_RDW,
        S_DONE
    } t_state;

    t_state             r_state,     n_state;
    logic [FUNC_W-1:0]  r_func,      n_func;
    logic [IDXW-1:0]    r_k,         n_k;
    logic [VALUE_W-1:0] r_val,       n_val;
    logic [CW-1:0]      r_ptr,       n_ptr;
    logic [CW-1:0]      r_count,     n_count;
    logic [STAT_W-1:0]  r_status,    n_status;
    logic [POS_W-1:0]   r_found,     n_found;
    logic [VALUE_W-1:0] r_data,      n_data;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out,       n_out;

    // entry RAM port
    logic               mem_we;
    logic [IDXW-1:0]    mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [IDXW-1:0]    mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    // shared pointer arithmetic and compare
    logic [CW-1:0]      ptr_inc;
    logic [CW-1:0]      ptr_dec;
    logic               hit;

    // input decode
    logic [CMPW-1:0]    pos_x;
    logic [CMPW-1:0]    cnt_x;
    logic               pos_nz;
    logic               in_range;
    logic               ins_range;
    logic               list_full;
    logic [POS_W-1:0]   pos_m1;

    sle_mem #(
        .DEPTH (CAPACITY),
        .AW    (IDXW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign ptr_inc = r_ptr + CW'(1);
    assign ptr_dec = r_ptr - CW'(1);
    assign hit     = (mem_rdata == r_val);

    // position checks against the count held before this operation
    assign pos_x     = CMPW'(i_in_data.position);
    assign cnt_x     = CMPW'(r_count);
    assign pos_nz    = (i_in_data.position != '0);
    assign in_range  = pos_nz && (pos_x <= cnt_x);
    assign ins_range = pos_nz && (pos_x <= cnt_x + CMPW'(1));
    assign list_full = (r_count == CW'(CAPACITY));
    assign pos_m1    = i_in_data.position - POS_W'(1);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_k         = r_k;
        n_val       = r_val;
        n_ptr       = r_ptr;
        n_count     = r_count;
        n_status    = r_status;
        n_found     = r_found;
        n_data      = r_data;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        mem_we    = 1'b0;
        mem_waddr = r_ptr[IDXW-1:0];
        mem_wdata = r_val;
        mem_raddr = r_ptr[IDXW-1:0];

        // result register drains independently of the sequencer
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func   = i_in_data.func;
                    n_k      = IDXW'(pos_m1);
                    n_val    = i_in_data.value;
                    n_status = STAT_OK;
                    n_found  = '0;
                    n_data   = '0;
                    n_state  = S_DONE;
                    case (i_in_data.func)
                        FUNC_DELETE: begin
                            if (!in_range) begin
                                n_status = STAT_BADPOS;
                            end else begin
                                n_ptr   = CW'(pos_m1);
                                n_state = S_DEL;
                            end
                        end
                        FUNC_INSERT: begin
                            if (!ins_range) begin
                                n_status = STAT_BADPOS;
                            end else if (list_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_ptr   = r_count;
                                n_state = S_INS;
                            end
                        end
                        FUNC_SEARCH: begin
                            n_ptr   = '0;
                            n_state = S_SRCH;
                        end
                        FUNC_MODIFY, FUNC_READ: begin
                            if (!in_range) begin
                                n_status = STAT_BADPOS;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            // unused func codes: ok status, no change
                            n_status = STAT_OK;
                        end
                    endcase
                end
            end
            // delete: move entry ptr+1 down to ptr until the tail
            S_DEL: begin
                if (ptr_inc < r_count) begin
                    mem_raddr = ptr_inc[IDXW-1:0];
                    n_state   = S_DELW;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DELW: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[IDXW-1:0];
                mem_wdata = mem_rdata;
                n_ptr     = ptr_inc;
                n_state   = S_DEL;
            end
            // insert: move entry ptr-1 up to ptr, from the tail down to k
            S_INS: begin
                if (r_ptr > CW'(r_k)) begin
                    mem_raddr = ptr_dec[IDXW-1:0];
                    n_state   = S_INSW;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_k;
                    mem_wdata = r_val;
                    n_count   = r_count + CW'(1);
                    n_state   = S_DONE;
                end
            end
            S_INSW: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[IDXW-1:0];
                mem_wdata = mem_rdata;
                n_ptr     = ptr_dec;
                n_state   = S_INS;
            end
            // search: first match wins
            S_SRCH: begin
                if (r_ptr < r_count) begin
                    mem_raddr = r_ptr[IDXW-1:0];
                    n_state   = S_SRCHW;
                end else begin
                    n_status = STAT_NOTFOUND;
                    n_state  = S_DONE;
                end
            end
            S_SRCHW: begin
                if (hit) begin
                    n_found = POS_W'(ptr_inc);
                    n_state = S_DONE;
                end else begin
                    n_ptr   = ptr_inc;
                    n_state = S_SRCH;
                end
            end
            // read and modify share the single entry fetch
            S_RD: begin
                mem_raddr = r_k;
                n_state   = S_RDW;
            end
            S_RDW: begin
                n_data = mem_rdata;
                if (r_func == FUNC_MODIFY) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_k;
                    mem_wdata = r_val;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status         = r_status;
                    n_out.found_position = r_found;
                    n_out.data           = r_data;
                    n_out.count          = POS_W'(r_count);
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_func      <= n_func;
            r_k         <= n_k;
            r_val       <= n_val;
            r_ptr       <= n_ptr;
            r_status    <= n_status;
            r_found     <= n_found;
            r_data      <= n_data;
            r_out       <= n_out;
        end
    end

    // list never grows past its capacity
    `SLE_ASSERT_ALWAYS(a_count_cap, r_count <= CW'(CAPACITY), "entry count above capacity")

    // count moves by at most one entry per cycle
    `SLE_ASSERT_ALWAYS(a_count_step,
        (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1)) ||
        (r_count == $past(r_count) - CW'(1)), "entry count jumped")

    // a new result only comes out of the completion state
    `SLE_ASSERT_IMP(a_out_src, $rose(o_out_valid), $past(r_state) == S_DONE,
        "result raised outside completion")

    // shifts and writes stay inside the live list plus one slot
    `SLE_ASSERT_IMP(a_wr_range, mem_we, CW'(mem_waddr) <= r_count,
        "entry write beyond list tail")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import sle_pkg::*;

    localparam int LIST_CAP     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 64;
    localparam int TIMEOUT_NS   = 4_000_000;

    // func codes the block treats as no-ops
    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

    // mirror of the list: applies each accepted op and queues the result it must give
    class list_mirror;
        logic signed [VALUE_W-1:0] entries [LIST_CAP];
        int unsigned               n_entries;
        t_out_item                 pending_results [$];
        int                        errors;

        function new();
            n_entries = 0;
            errors    = 0;
        endfunction

        function void apply_op(t_in_item op);
            t_out_item   res;
            int unsigned pos;
            int          k;
            res    = '0;
            pos    = op.position;
            case (op.func)
                FUNC_DELETE: begin
                    if (pos < 1 || pos > n_entries) begin
                        res.status = STAT_BADPOS;
                    end else begin
                        for (k = pos - 1; k + 1 < n_entries; k++) entries[k] = entries[k + 1];
                        n_entries--;
                    end
                end
                FUNC_INSERT: begin
                    // position is checked before the full test
                    if (pos < 1 || pos > n_entries + 1) begin
                        res.status = STAT_BADPOS;
                    end else if (n_entries >= LIST_CAP) begin
                        res.status = STAT_FULL;
                    end else begin
                        for (k = n_entries; k > pos - 1; k--) entries[k] = entries[k - 1];
                        entries[pos - 1] = op.value;
                        n_entries++;
                    end
                end
                FUNC_SEARCH: begin
                    res.status = STAT_NOTFOUND;
                    for (k = 0; k < n_entries && res.status != STAT_OK; k++) begin
                        if (entries[k] == op.value) begin
                            res.status         = STAT_OK;
                            res.found_position = k + 1;
                        end
                    end
                end
                FUNC_MODIFY: begin
                    if (pos < 1 || pos > n_entries) begin
                        res.status = STAT_BADPOS;
                    end else begin
                        res.data         = entries[pos - 1];
                        entries[pos - 1] = op.value;
                    end
                end
                FUNC_READ: begin
                    if (pos < 1 || pos > n_entries) begin
                        res.status = STAT_BADPOS;
                    end else begin
                        res.data = entries[pos - 1];
                    end
                end
                default: begin
                    res.status = STAT_OK;
                end
            endcase
            res.count = n_entries[POS_W-1:0];
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("found_position", want.found_position, got.found_position);
            compare_field("data", want.data, got.data);
            compare_field("count", want.count, got.count);
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    list_mirror mirror;
    bit         steady   = 1'b0;   // no idling on either side while set
    bit         hold_req = 1'b0;   // asks the receiver for one long hold-off
    int         items_sent = 0;

    sequential_list_engine u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (steady || $urandom_range(0, 2) != 0) return 0;
        return idle_len();
    endfunction

    function automatic t_in_item mk(logic [FUNC_W-1:0] f, int unsigned p, logic [31:0] v);
        t_in_item op;
        op.func     = f;
        op.position = p[POS_W-1:0];
        op.value    = v;
        return op;
    endfunction

    // value with a good chance of matching something already in the list
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3 && mirror.n_entries > 0) return mirror.entries[$urandom_range(0, mirror.n_entries - 1)];
        if (r < 5) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
        if (r < 7) return $urandom_range(0, 7);
        return $urandom;
    endfunction

    // mostly in range; sometimes anything the field can hold
    function automatic int unsigned pick_pos(bit for_insert);
        int unsigned limit;
        limit = mirror.n_entries + (for_insert ? 1 : 0);
        if (limit == 0 || $urandom_range(0, 99) < 15) return $urandom_range(0, 31);
        return $urandom_range(1, limit);
    endfunction

    // one input transfer; returns at the falling edge after it is taken
    task automatic send_item(input t_in_item op);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= op;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        while (mirror.pending_results.size() != 0) @(negedge i_clk);
    endtask

    // grow the list to capacity, then knock on the full list
    task automatic fill_list();
        int unsigned p;
        while (mirror.n_entries < LIST_CAP) begin
            p = ($urandom_range(0, 1) == 0) ? mirror.n_entries + 1
                                            : $urandom_range(1, mirror.n_entries + 1);
            send_item(mk(FUNC_INSERT, p, pick_value()));
        end
        send_item(mk(FUNC_INSERT, LIST_CAP + 1, pick_value()));
        send_item(mk(FUNC_INSERT, $urandom_range(1, LIST_CAP), pick_value()));
        send_item(mk(FUNC_INSERT, $urandom_range(LIST_CAP + 2, 31), pick_value()));
        send_item(mk(FUNC_SEARCH, 0, pick_value()));
    endtask

    // empty the list with a few lookups mixed in
    task automatic drain_list();
        while (mirror.n_entries > 0) begin
            if ($urandom_range(0, 3) == 0)
                send_item(mk(FUNC_READ, pick_pos(1'b0), $urandom));
            else
                send_item(mk(FUNC_DELETE, $urandom_range(1, mirror.n_entries), $urandom));
        end
        send_item(mk(FUNC_DELETE, pick_pos(1'b0), $urandom));
        send_item(mk(FUNC_SEARCH, 0, pick_value()));
    endtask

    task automatic mixed_ops(input int len);
        int r;
        repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 25)      send_item(mk(FUNC_INSERT, pick_pos(1'b1), pick_value()));
            else if (r < 45) send_item(mk(FUNC_DELETE, pick_pos(1'b0), $urandom));
            else if (r < 65) send_item(mk(FUNC_SEARCH, $urandom_range(0, 31), pick_value()));
            else if (r < 80) send_item(mk(FUNC_MODIFY, pick_pos(1'b0), pick_value()));
            else if (r < 95) send_item(mk(FUNC_READ, pick_pos(1'b0), $urandom));
            else send_item(mk(FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)),
                              $urandom_range(0, 31), $urandom));
        end
    endtask

    // anything the fields can hold
    task automatic noise_ops(input int len);
        repeat (len) send_item(mk(FUNC_W'($urandom_range(0, 7)), $urandom_range(0, 31), $urandom));
    endtask

    // every accepted transfer goes to the mirror, every result is checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) mirror.apply_op(i_in_data);
            if (o_out_valid && i_out_ready) mirror.check_result(o_out_data);
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
                stall    = 0;
            end else if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                stall = idle_len() - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        bit hold_done;
        hold_done = 1'b0;
        mirror    = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty list, both ends of the value range, appends,
        // duplicates, misses, out-of-range positions and spare func codes
        send_item(mk(FUNC_READ,   1, 32'h0000_0000));
        send_item(mk(FUNC_DELETE, 1, 32'h0000_0000));
        send_item(mk(FUNC_MODIFY, 1, 32'h1234_5678));
        send_item(mk(FUNC_SEARCH, 0, 32'h0000_0000));
        send_item(mk(FUNC_INSERT, 0, 32'h0000_0001));
        send_item(mk(FUNC_INSERT, 2, 32'h0000_0001));
        send_item(mk(FUNC_INSERT, 1, 32'h7FFF_FFFF));
        send_item(mk(FUNC_INSERT, 2, 32'h8000_0000));
        send_item(mk(FUNC_INSERT, 1, 32'h0000_0000));
        send_item(mk(FUNC_INSERT, 2, 32'hFFFF_FFFF));
        send_item(mk(FUNC_INSERT, 5, 32'h0000_0000));
        send_item(mk(FUNC_SEARCH, 0, 32'h0000_0000));
        send_item(mk(FUNC_SEARCH, 31, 32'h8000_0000));
        send_item(mk(FUNC_SEARCH, 0, 32'hAAAA_AAAA));
        send_item(mk(FUNC_MODIFY, 5, 32'h5555_5555));
        send_item(mk(FUNC_READ,   5, 32'h0000_0000));
        send_item(mk(FUNC_READ,   6, 32'h0000_0000));
        send_item(mk(FUNC_READ,   31, 32'h0000_0000));
        send_item(mk(FUNC_INSERT, 31, 32'h0000_0002));
        send_item(mk(FUNC_DELETE, 1, 32'h0000_0000));
        send_item(mk(FUNC_DELETE, 4, 32'h0000_0000));
        send_item(mk(FUNC_DELETE, 2, 32'h0000_0000));
        send_item(mk(FUNC_SPARE_FIRST, 1, 32'hFFFF_FFFF));
        send_item(mk(FUNC_SPARE_LAST, 31, 32'h0000_0000));

        // sender pauses until the block has answered everything
        i_in_valid <= 1'b0;
        wait_drained();

        // random part: well-formed bursts with random content, some noise
        while (items_sent < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 4) == 0);
            if (!hold_done && items_sent > 400) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1:    fill_list();
                2, 3:    drain_list();
                4:       noise_ops($urandom_range(5, 15));
                default: mixed_ops($urandom_range(10, 40));
            endcase
            if ($urandom_range(0, 7) == 0) begin
                i_in_valid <= 1'b0;
                wait_drained();
            end
        end

        i_in_valid <= 1'b0;
        steady = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mirror.pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, mirror.pending_results.size());
            mirror.errors++;
        end
        if (mirror.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
